// ===== design/ctih_pkg.sv =====
// ----------------------------------------------------------------------------
// ctih_pkg
// Shared types and constants of the character trigram hash indexer: field
// widths, the register map and the word that moves along the divider chain.
// ----------------------------------------------------------------------------
package ctih_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CODE_W  = 6;
  localparam int unsigned PADDR_W = 3;

  // The trigram hash never exceeds 36 * (1 + 37 + 1369) = 50652, so the hash,
  // the modulus and every partial remainder fit in sixteen bits.
  localparam int unsigned HASH_W   = 16;
  localparam int unsigned FULL_DIM = 50653;
  localparam int unsigned HASH_MAX = FULL_DIM - 1;
  localparam int unsigned WEIGHT_1 = 37;
  localparam int unsigned WEIGHT_2 = 1369;

  // One divider cell for each dividend bit.
  localparam int unsigned NUM_CELLS = HASH_W;

  // Register map, indexed by word address.
  typedef enum logic {
    REG_MAX_DIM      = 1'b0,
    REG_START_OFFSET = 1'b1
  } ctih_reg_t;

  // Word handed from one divider cell to the next.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [HASH_W-1:0] rem;
    logic [HASH_W-1:0] num;
  } ctih_slot_t;

endpackage

// ===== design/ctih_if.sv =====
// ----------------------------------------------------------------------------
// ctih_if
// Valid/ready channels of the trigram hash indexer: the text byte channel and
// the feature index channel.
// ----------------------------------------------------------------------------

// Text byte channel.
interface ctih_in_if
  import ctih_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              string_end;

  modport source (output valid, output text_byte, output string_end, input ready);
  modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

// Feature index channel.
interface ctih_out_if
  import ctih_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] feature_index;
  logic              string_done;

  modport source (output valid, output feature_index, output string_done, input ready);
  modport sink   (input valid, input feature_index, input string_done, output ready);
endinterface

// ===== design/ctih_window.sv =====
// ----------------------------------------------------------------------------
// ctih_window
// Front stage: maps each byte to its code, keeps the two previous codes of the
// current string and forms the weighted trigram sum for the divider chain.
// ----------------------------------------------------------------------------
module ctih_window
  import ctih_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              string_end,
  input  logic              en,
  output ctih_slot_t        slot_o
);

  logic [CODE_W-1:0] older_r, older_nxt;
  logic [CODE_W-1:0] newer_r, newer_nxt;
  logic [1:0]        seen_r, seen_nxt;
  ctih_slot_t        slot_r, slot_nxt;
  logic [CODE_W-1:0] code;
  logic [HASH_W-1:0] hash;

  // Space, digits and letters get their own codes; anything else reads as space.
  function automatic logic [CODE_W-1:0] byte_code(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] c;
    c = '0;
    priority if (b >= 8'd48 && b <= 8'd57) begin
      c = CODE_W'(b - 8'd47);
    end else if (b >= 8'd65 && b <= 8'd90) begin
      c = CODE_W'(b - 8'd54);
    end else if (b >= 8'd97 && b <= 8'd122) begin
      c = CODE_W'(b - 8'd86);
    end else begin
      c = '0;
    end
    return c;
  endfunction

  assign code = byte_code(text_byte);
  assign hash = HASH_W'(older_r) + HASH_W'(newer_r) * HASH_W'(WEIGHT_1)
              + HASH_W'(code) * HASH_W'(WEIGHT_2);

  // Window update: shift in the new code, or clear at the end of a string.
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (string_end) begin
        older_nxt = '0;
        newer_nxt = '0;
        seen_nxt  = '0;
      end else begin
        older_nxt = newer_r;
        newer_nxt = code;
        seen_nxt  = seen_r[1] ? seen_r : seen_r + 2'd1;
      end
    end
  end

  // A word enters the chain from the third byte of a string on.
  always_comb begin
    slot_nxt.valid = accept && seen_r[1];
    slot_nxt.done  = string_end;
    slot_nxt.rem   = '0;
    slot_nxt.num   = hash;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      seen_r  <= '0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Output stage register; only the valid bit needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

// ===== design/ctih_cell.sv =====
// ----------------------------------------------------------------------------
// ctih_cell
// One restoring division step: brings down the next dividend bit and subtracts
// the modulus where it fits, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module ctih_cell
  import ctih_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [HASH_W-1:0] modulus,
  input  ctih_slot_t        slot_i,
  output ctih_slot_t        slot_o
);

  ctih_slot_t      slot_r, slot_nxt;
  logic [HASH_W:0] trial;
  logic [HASH_W:0] diff;

  // Trial subtraction of the modulus from the shifted partial remainder.
  assign trial = {slot_i.rem, slot_i.num[HASH_W-1]};
  assign diff  = trial - {1'b0, modulus};

  always_comb begin
    slot_nxt.valid = slot_i.valid;
    slot_nxt.done  = slot_i.done;
    slot_nxt.rem   = diff[HASH_W] ? trial[HASH_W-1:0] : diff[HASH_W-1:0];
    slot_nxt.num   = {slot_i.num[HASH_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

// ===== design/char_trigram_hash_indexer_core.sv =====
// ----------------------------------------------------------------------------
// char_trigram_hash_indexer_core
// Character trigram feature hasher: one text byte in per word, one feature
// index out for each trigram, reduced modulo min(50653, max_dim), zero read as one, by a
// chain of division cells and offset by start_offset.
//
//   Channel   Direction  Handshake          Word
//   in_word   input      valid / ready      text_byte, string_end
//   out_word  output     valid / ready      feature_index, string_done
//   APB       input      psel/penable/...   max_dim (0x0), start_offset (0x4)
//
// A byte word is taken in every cycle unless a stalled output has filled the chain;
// a feature index passes through the window stage, sixteen division cells and the
// offset register. The sixteen-cell divider chain takes one dividend bit a cell.
// Reset is synchronous: it empties the chain and the window and sets
// max_dim to 50653 and start_offset to 0.
// Each stage holds while the one after it is full and stalled; empty stages
// are filled up behind a stalled output, so short strings leave no gaps.
// ----------------------------------------------------------------------------
module char_trigram_hash_indexer_core
  import ctih_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  ctih_in_if.sink            in_word,
  ctih_out_if.source         out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready
);

  logic [WORD_W-1:0] max_dim_r;
  logic [WORD_W-1:0] start_offset_r;
  logic [HASH_W-1:0] mod_r, mod_nxt;
  ctih_reg_t         reg_sel;
  logic              cfg_wr;

  ctih_slot_t        slot [NUM_CELLS+1];
  logic              cell_en [NUM_CELLS];
  logic              win_en;
  logic              in_fire;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_index_r;
  logic              out_done_r;
  logic              out_en;

  // Register access decode.
  assign pready  = 1'b1;
  assign reg_sel = ctih_reg_t'(paddr[PADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_MAX_DIM:      prdata = max_dim_r;
      REG_START_OFFSET: prdata = start_offset_r;
      default:          prdata = '0;
    endcase
  end

  // Effective modulus: the smaller of max_dim and the full table, zero as one.
  always_comb begin
    priority if (pwdata == '0) begin
      mod_nxt = HASH_W'(1);
    end else if (pwdata < WORD_W'(FULL_DIM)) begin
      mod_nxt = pwdata[HASH_W-1:0];
    end else begin
      mod_nxt = HASH_W'(FULL_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r      <= WORD_W'(FULL_DIM);
      mod_r          <= HASH_W'(FULL_DIM);
      start_offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MAX_DIM: begin
          max_dim_r <= pwdata;
          mod_r     <= mod_nxt;
        end
        REG_START_OFFSET: begin
          start_offset_r <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Stage enables: a stage moves when the one after it is empty or moving.
  assign out_en = !out_valid_r || out_word.ready;

  always_comb begin
    for (int k = NUM_CELLS - 1; k >= 0; k--) begin
      if (k == NUM_CELLS - 1) begin
        cell_en[k] = !slot[k+1].valid || out_en;
      end else begin
        cell_en[k] = !slot[k+1].valid || cell_en[k+1];
      end
    end
  end

  assign win_en        = !slot[0].valid || cell_en[0];
  assign in_word.ready = win_en;
  assign in_fire       = in_word.valid && win_en;

  // Byte window and hash.
  ctih_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_fire),
    .text_byte  (in_word.text_byte),
    .string_end (in_word.string_end),
    .en         (win_en),
    .slot_o     (slot[0])
  );

  // Division chain, one cell a dividend bit.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ctih_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (cell_en[k]),
      .modulus (mod_r),
      .slot_i  (slot[k]),
      .slot_o  (slot[k+1])
    );
  end

  // Output register: remainder plus offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= slot[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_index_r <= WORD_W'(slot[NUM_CELLS].rem) + start_offset_r;
      out_done_r  <= slot[NUM_CELLS].done;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.feature_index = out_index_r;
  assign out_word.string_done   = out_done_r;

  // The weighted trigram sum never reaches the full table size.
  a_hash_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot[0].valid |-> slot[0].num <= HASH_W'(HASH_MAX))
    else $error("trigram sum above the table size");

  // A result only appears when the last cell held a word the cycle before.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(slot[NUM_CELLS].valid))
    else $error("result word without a word in the last cell");

  // The input is only held off while the front stage is full.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> slot[0].valid)
    else $error("input stalled with an empty front stage");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character trigram hash indexer. Text strings are
// streamed in over the byte channel; a behavioural hasher works out the
// feature index of every trigram. Each word on the feature channel is checked
// against the oldest prediction. In some phases the input has random gaps and
// the output random stalls. The APB registers are rewritten between phases so
// that the modulus and offset run through their extremes, with a zero modulus.
// ----------------------------------------------------------------------------
module tb
  import ctih_pkg::*;
();

  // One byte word waiting to be sent.
  typedef struct {
    logic [BYTE_W-1:0] text_byte;
    logic              string_end;
  } text_word_t;

  // One predicted feature word.
  typedef struct {
    logic [WORD_W-1:0] feature_index;
    logic              string_done;
  } feature_t;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_BYTES   = 225;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // APB port, held idle from the start of the run.
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [WORD_W-1:0]  pwdata  = '0;
  logic [WORD_W-1:0]  prdata;
  logic               pready;

  ctih_in_if  in_ch ();
  ctih_out_if out_ch ();

  char_trigram_hash_indexer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Words still to be sent and feature indices still to be seen.
  text_word_t text_q[$];
  feature_t   expected_features[$];
  text_word_t next_word;

  // Hasher state and its copy of the registers.
  logic [CODE_W-1:0] older_code;
  logic [CODE_W-1:0] newer_code;
  logic [1:0]        window_fill;
  logic [WORD_W-1:0] dim_limit;
  logic [WORD_W-1:0] index_offset;

  int  source_gap;
  int  sink_stall;
  bit  quiet_source;
  bit  quiet_sink;
  int  error_count      = 0;
  int  bytes_accepted   = 0;
  int  strings_queued   = 0;
  int  features_checked = 0;

  always #2 clk = ~clk;

  // Maps a raw byte onto its 37-letter alphabet code.
  function automatic logic [CODE_W-1:0] char_code(logic [BYTE_W-1:0] b);
    if (b >= 8'h30 && b <= 8'h39) return CODE_W'(b - 8'h30 + 1);
    if (b >= 8'h41 && b <= 8'h5a) return CODE_W'(b - 8'h41 + 11);
    if (b >= 8'h61 && b <= 8'h7a) return CODE_W'(b - 8'h61 + 11);
    return '0;
  endfunction

  // Advances the window by one accepted byte and predicts its feature word.
  task automatic hash_text_byte(logic [BYTE_W-1:0] b, logic last);
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] hash;
    feature_t          feat;
    code = char_code(b);
    if (window_fill == 2'd2) begin
      modulus = (dim_limit < FULL_DIM) ? dim_limit : WORD_W'(FULL_DIM);
      if (modulus == '0) modulus = 1;
      hash = WORD_W'(older_code) + WORD_W'(WEIGHT_1) * WORD_W'(newer_code)
           + WORD_W'(WEIGHT_2) * WORD_W'(code);
      feat.feature_index = (hash % modulus) + index_offset;
      feat.string_done   = last;
      expected_features.push_back(feat);
    end
    if (last) begin
      older_code  = '0;
      newer_code  = '0;
      window_fill = '0;
    end else begin
      older_code = newer_code;
      newer_code = code;
      if (window_fill != 2'd2) window_fill = window_fill + 2'd1;
    end
  endtask

  // Byte driver: presents queued words, random gap after each one if not quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.text_byte  <= '0;
      in_ch.string_end <= 1'b0;
      older_code  = '0;
      newer_code  = '0;
      window_fill = '0;
      source_gap  = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        hash_text_byte(in_ch.text_byte, in_ch.string_end);
        bytes_accepted++;
      end
      if (source_gap > 0) begin
        source_gap--;
        in_ch.valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        next_word = text_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.text_byte  <= next_word.text_byte;
        in_ch.string_end <= next_word.string_end;
        source_gap = quiet_source ? 0 : $urandom_range(0, 19);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Feature monitor: checks every accepted word, stalls at random unless quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_features.size() == 0) begin
          $error("feature word with none expected: feature_index %0h string_done %0b",
                 out_ch.feature_index, out_ch.string_done);
          error_count++;
        end else begin
          if (out_ch.feature_index !== expected_features[0].feature_index) begin
            $error("feature_index: expected %0h, actual %0h",
                   expected_features[0].feature_index, out_ch.feature_index);
            error_count++;
          end
          if (out_ch.string_done !== expected_features[0].string_done) begin
            $error("string_done: expected %0b, actual %0b",
                   expected_features[0].string_done, out_ch.string_done);
            error_count++;
          end
          void'(expected_features.pop_front());
        end
        features_checked++;
        sink_stall = quiet_sink ? 0 : $urandom_range(0, 19);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end
      out_ch.ready <= (sink_stall == 0);
    end
  end

  // APB write: setup cycle, then access cycle; the register takes it at the
  // edge that closes the access cycle.
  task automatic cfg_write(ctih_reg_t sel, logic [WORD_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(sel));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_MAX_DIM:      dim_limit    = value;
      REG_START_OFFSET: index_offset = value;
      default: ;
    endcase
  endtask

  // Waits until the sender is drained, every feature has come back and the
  // divider chain has had time to empty.
  task automatic wait_idle();
    do @(negedge clk);
    while (text_q.size() != 0 || in_ch.valid || expected_features.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_byte(logic [BYTE_W-1:0] b, logic last);
    text_word_t w;
    w.text_byte  = b;
    w.string_end = last;
    text_q.push_back(w);
    if (last) strings_queued++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  // Mostly letters, digits and spaces, with arbitrary bytes mixed in.
  function automatic logic [BYTE_W-1:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return BYTE_W'($urandom_range(0, 255));
      3:       return 8'h20;
      4:       return BYTE_W'($urandom_range(8'h30, 8'h39));
      5, 6:    return BYTE_W'($urandom_range(8'h41, 8'h5a));
      default: return BYTE_W'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  // Random strings: mostly words of ordinary length, some short ones that
  // yield nothing, and now and then a long run.
  task automatic queue_random_strings(int unsigned n_bytes);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    while (queued < n_bytes) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 2);
        2:       len = $urandom_range(13, 40);
        default: len = $urandom_range(3, 12);
      endcase
      for (int i = 0; i < len; i++) queue_byte(pick_text_byte(), i == len - 1);
      queued += len;
    end
  endtask

  // Main sequence: reset, directed strings, then phases of random text under
  // different register settings.
  initial begin
    logic [BYTE_W-1:0] boundary_bytes[15];
    boundary_bytes = '{8'h20, 8'h30, 8'h39, 8'h41, 8'h5a, 8'h61, 8'h7a, 8'h2f,
                       8'h3a, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h00, 8'hff};
    dim_limit        = FULL_DIM;
    index_offset     = '0;
    quiet_source     = 1'b0;
    quiet_sink       = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: short strings, the largest hash and the character
    // class boundaries, including the lowest and highest byte.
    queue_text("A");
    queue_text("b9");
    queue_text("zzZ");
    foreach (boundary_bytes[i]) queue_byte(boundary_bytes[i], i == 14);
    wait_idle();

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          cfg_write(REG_MAX_DIM, 32'd1);
          cfg_write(REG_START_OFFSET, 32'hffff_ffff);
        end
        2: begin
          // A zero modulus behaves as one: only the offset remains.
          cfg_write(REG_MAX_DIM, 32'd0);
          cfg_write(REG_START_OFFSET, $urandom);
        end
        3: begin
          cfg_write(REG_MAX_DIM, 32'hffff_ffff);
          cfg_write(REG_START_OFFSET, 32'hffff_ff00);
        end
        4: begin
          cfg_write(REG_MAX_DIM, FULL_DIM - 1);
          cfg_write(REG_START_OFFSET, 32'd0);
        end
        5: begin
          cfg_write(REG_MAX_DIM, FULL_DIM + 1);
          cfg_write(REG_START_OFFSET, $urandom);
        end
        6: begin
          cfg_write(REG_MAX_DIM, $urandom_range(2, 1500));
          cfg_write(REG_START_OFFSET, $urandom);
        end
        7: begin
          cfg_write(REG_MAX_DIM, $urandom);
          cfg_write(REG_START_OFFSET, 32'd0);
        end
        default: ;
      endcase
      quiet_source = (phase % 4 == 1) || (phase % 4 == 3);
      quiet_sink   = (phase % 4 == 2) || (phase % 4 == 3);
      @(negedge clk);
      queue_random_strings(PHASE_BYTES);
      wait_idle();
    end

    $display("Sent %0d bytes in %0d strings; checked %0d feature words.",
             bytes_accepted, strings_queued, features_checked);
    $display("Covered %0d register settings, a zero modulus and offset wrap-around.",
             NUM_PHASES);
    if (error_count == 0) begin
      $display("char_trigram_hash_indexer_core test passed");
    end else begin
      $display("char_trigram_hash_indexer_core test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("char_trigram_hash_indexer_core test failed");
    $finish;
  end

endmodule
